>>> rtl/core/ring_list_with_indexed_removal_defines.svh
// Assertion macros for the checker file of the ring list block.
`ifndef RING_LIST_WITH_INDEXED_REMOVAL_DEFINES_SVH
`define RING_LIST_WITH_INDEXED_REMOVAL_DEFINES_SVH

// Same-cycle implication, sampled on i_clk, off during reset
`define RLIR_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("ring list check failed");

// Next-cycle implication, sampled on i_clk, off during reset
`define RLIR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("ring list check failed");

`endif

>>> rtl/core/rlir_pkg.sv
// Shared constants, codes and types of the ring list block.
package rlir_pkg;

    localparam int DEPTH       = 64;
    localparam int ENTRY_WIDTH = 32;
    localparam int AW          = $clog2(DEPTH);
    localparam int CW          = $clog2(DEPTH + 1);

    localparam int FUNC_W      = 2;
    localparam int INDEX_W     = 6;
    localparam int ENTRY_IN_W  = 32;
    localparam int ENTRY_OUT_W = 32;
    localparam int LENGTH_W    = 7;
    localparam int STATUS_W    = 2;

    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 48;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_APPEND = 2'd0,
        FUNC_REMOVE = 2'd1,
        FUNC_READ   = 2'd2,
        FUNC_CLEAR  = 2'd3
    } t_func;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK    = 2'd0,
        STATUS_FULL  = 2'd1,
        STATUS_RANGE = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RD_WAIT,
        ST_SHIFT,
        ST_DONE
    } t_state;

endpackage

>>> rtl/core/rlir_ram.sv
// Simple dual-port synchronous RAM: one write port, one registered read port.
module rlir_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 32,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read port, registered
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/core/ring_list_with_indexed_removal.sv
// Ring list with indexed removal: top level, control FSM and list pointers.
//
// Usage: each item on the s_axis channel carries one operation in tuser
// (append, remove at index, read at index, clear) with index and entry data
// in tdata. Every item gives exactly one result item on m_axis: entry read,
// list length after the operation, and a status (ok, full, index out of range).
// Items are handled one at a time; s_axis_tready is high while the block idles.
// Steps per item: append, clear, front or back removal and any failed
// operation go from accept straight to the result state; a read passes a RAM
// read wait state first; a removal in the middle passes a shift state that
// moves the m entries on the shorter side of the gap (at most DEPTH/2 - 1),
// one entry per cycle through the entry RAM's single read and single write
// port in a pipelined read-then-write-back loop. The result item is loaded
// into the output register as the block returns to idle.
// A result waits in the output register while m_axis_tready is low; the next
// item is accepted meanwhile and its work finishes, then it holds until the
// output register frees up.
// Reset (i_rst_n low, synchronous) empties the list and drops m_axis_tvalid;
// RAM contents are not cleared, no clearing pass is needed.
module ring_list_with_indexed_removal
    import rlir_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // fields from bit 0: index[5:0], entry_in[37:6], zero fill
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // fields from bit 0: func[1:0]
    input  logic [FUNC_W-1:0]      s_axis_tuser,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // fields from bit 0: entry_out[31:0], length[38:32], zero fill
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    // fields from bit 0: status[1:0]
    output logic [STATUS_W-1:0]    m_axis_tuser
);

    // physical slot of logical position i
    function automatic logic [AW-1:0] phys(input logic [AW-1:0] head,
                                           input logic [AW-1:0] i);
        logic [AW:0] sum;
        sum = {1'b0, head} + {1'b0, i};
        if (sum >= (AW+1)'(DEPTH)) begin
            sum = sum - (AW+1)'(DEPTH);
        end
        return sum[AW-1:0];
    endfunction

    t_state                 r_state, n_state;
    logic [AW-1:0]          r_head, n_head;
    logic [CW-1:0]          r_count, n_count;
    t_status                r_status, n_status;
    logic [ENTRY_OUT_W-1:0] r_entry, n_entry;
    logic [AW-1:0]          r_wr, n_wr;
    logic [AW-1:0]          r_rd, n_rd;
    logic [CW-1:0]          r_left, n_left;
    logic                   r_front, n_front;
    logic                   r_out_valid, n_out_valid;
    logic [ENTRY_OUT_W-1:0] r_out_entry, n_out_entry;
    logic [LENGTH_W-1:0]    r_out_len, n_out_len;
    t_status                r_out_status, n_out_status;

    logic                   in_accept;
    t_func                  in_func;
    logic [INDEX_W-1:0]     in_index;
    logic [ENTRY_IN_W-1:0]  in_entry;
    logic [CW-1:0]          idx_c;
    logic [AW-1:0]          idx_a;
    logic                   in_range;
    logic                   is_front;
    logic                   need_shift;
    logic                   need_read;
    logic                   out_free;

    logic                   ram_we;
    logic [AW-1:0]          ram_waddr;
    logic [ENTRY_WIDTH-1:0] ram_wdata;
    logic [AW-1:0]          rd_log;
    logic [ENTRY_WIDTH-1:0] ram_rdata;

    // input unpacking and decode
    assign in_accept = s_axis_tvalid && s_axis_tready;
    assign in_func   = t_func'(s_axis_tuser);
    assign in_index  = s_axis_tdata[INDEX_W-1:0];
    assign in_entry  = s_axis_tdata[INDEX_W +: ENTRY_IN_W];
    assign idx_c     = CW'(in_index);
    assign idx_a     = AW'(in_index);
    assign in_range  = idx_c < r_count;
    assign is_front  = idx_c < (r_count >> 1);
    assign out_free  = !r_out_valid || m_axis_tready;

    // middle removal needs a shift; read needs a RAM access
    assign need_shift = (in_func == FUNC_REMOVE) && in_range && (idx_c != '0) &&
                        ((idx_c + CW'(1)) != r_count);
    assign need_read  = (in_func == FUNC_READ) && in_range;

    assign s_axis_tready = (r_state == ST_IDLE);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_accept) begin
                    if (need_read) begin
                        n_state = ST_RD_WAIT;
                    end else if (need_shift) begin
                        n_state = ST_SHIFT;
                    end else begin
                        n_state = ST_DONE;
                    end
                end
            end
            ST_RD_WAIT: n_state = ST_DONE;
            ST_SHIFT: begin
                if (r_left == CW'(1)) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // datapath, RAM control and result register
    always_comb begin
        n_head       = r_head;
        n_count      = r_count;
        n_status     = r_status;
        n_entry      = r_entry;
        n_wr         = r_wr;
        n_rd         = r_rd;
        n_left       = r_left;
        n_front      = r_front;
        n_out_valid  = r_out_valid && !m_axis_tready;
        n_out_entry  = r_out_entry;
        n_out_len    = r_out_len;
        n_out_status = r_out_status;
        ram_we       = 1'b0;
        ram_waddr    = phys(r_head, r_wr);
        ram_wdata    = ram_rdata;
        rd_log       = r_rd;
        case (r_state)
            ST_IDLE: begin
                if (in_accept) begin
                    n_status = STATUS_OK;
                    n_entry  = '0;
                    case (in_func)
                        FUNC_APPEND: begin
                            if (r_count == CW'(DEPTH)) begin
                                n_status = STATUS_FULL;
                            end else begin
                                ram_we    = 1'b1;
                                ram_waddr = phys(r_head, r_count[AW-1:0]);
                                ram_wdata = in_entry[ENTRY_WIDTH-1:0];
                                n_count   = r_count + CW'(1);
                            end
                        end
                        FUNC_REMOVE: begin
                            if (!in_range) begin
                                n_status = STATUS_RANGE;
                            end else if (idx_c == '0) begin
                                // front entry: the head moves and the count shrinks
                                n_head  = phys(r_head, AW'(1));
                                n_count = r_count - CW'(1);
                            end else if ((idx_c + CW'(1)) == r_count) begin
                                // last entry: only the count shrinks
                                n_count = r_count - CW'(1);
                            end else if (is_front) begin
                                // front part moves one place toward the back
                                n_front = 1'b1;
                                rd_log  = idx_a - AW'(1);
                                n_rd    = idx_a - AW'(2);
                                n_wr    = idx_a;
                                n_left  = idx_c;
                            end else begin
                                // back part moves one place toward the front
                                n_front = 1'b0;
                                rd_log  = idx_a + AW'(1);
                                n_rd    = idx_a + AW'(2);
                                n_wr    = idx_a;
                                n_left  = r_count - CW'(1) - idx_c;
                            end
                        end
                        FUNC_READ: begin
                            if (!in_range) begin
                                n_status = STATUS_RANGE;
                            end else begin
                                rd_log = idx_a;
                            end
                        end
                        FUNC_CLEAR: begin
                            n_count = '0;
                            n_head  = '0;
                        end
                        default: n_status = STATUS_OK;
                    endcase
                end
            end
            ST_RD_WAIT: begin
                n_entry = ENTRY_OUT_W'(ram_rdata);
            end
            ST_SHIFT: begin
                // write back the entry read last cycle, issue the next read
                ram_we = 1'b1;
                n_wr   = r_front ? (r_wr - AW'(1)) : (r_wr + AW'(1));
                n_rd   = r_front ? (r_rd - AW'(1)) : (r_rd + AW'(1));
                n_left = r_left - CW'(1);
                if (r_left == CW'(1)) begin
                    n_count = r_count - CW'(1);
                    if (r_front) begin
                        n_head = phys(r_head, AW'(1));
                    end
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_entry  = r_entry;
                    n_out_len    = LENGTH_W'(r_count);
                    n_out_status = r_status;
                end
            end
            default: n_status = r_status;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_head      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_status     <= n_status;
        r_entry      <= n_entry;
        r_wr         <= n_wr;
        r_rd         <= n_rd;
        r_left       <= n_left;
        r_front      <= n_front;
        r_out_entry  <= n_out_entry;
        r_out_len    <= n_out_len;
        r_out_status <= n_out_status;
    end

    // entry store
    rlir_ram #(
        .DEPTH (DEPTH),
        .WIDTH (ENTRY_WIDTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (phys(r_head, rd_log)),
        .o_rdata (ram_rdata)
    );

    // output packing
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {(OUT_TDATA_W - ENTRY_OUT_W - LENGTH_W)'(0), r_out_len, r_out_entry};
    assign m_axis_tuser  = r_out_status;

endmodule

>>> rtl/core/rlir_checker.sv
// Port-level checks of the ring list block, bound to the top level.
`include "ring_list_with_indexed_removal_defines.svh"

module rlir_checker
    import rlir_pkg::*;
(
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   m_axis_tvalid,
    input logic                   m_axis_tready,
    input logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input logic [STATUS_W-1:0]    m_axis_tuser
);

    // a stalled result holds
    `RLIR_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

    // list never grows past the store
    `RLIR_ASSERT_IMPL(a_len_max, m_axis_tvalid, m_axis_tdata[38:32] <= LENGTH_W'(DEPTH))

    // full is only reported with a full list
    `RLIR_ASSERT_IMPL(a_full_len, m_axis_tvalid && (m_axis_tuser == STATUS_FULL), m_axis_tdata[38:32] == LENGTH_W'(DEPTH))

    // failed operations return no entry data
    `RLIR_ASSERT_IMPL(a_err_zero, m_axis_tvalid && (m_axis_tuser != STATUS_OK), m_axis_tdata[31:0] == '0)

endmodule

bind ring_list_with_indexed_removal rlir_checker u_rlir_checker (.*);
